>>> hdl/acfvg_pkg.sv
// Shared package for the analog clock face vector generator.
// Holds geometry constants, the register index codes and the Q15 sine table.
// No dependencies.
package acfvg_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int COORD_W    = 12;

  localparam int NUM_TICKS = 60;
  localparam int NUM_CMDS  = 62;
  localparam int CMD_IDX_W = 6;

  localparam int DEF_WIDTH      = 400;
  localparam int DEF_HEIGHT     = 300;
  localparam int DEF_CX_OFFSET  = 0;
  localparam int DEF_CY_OFFSET  = 8;

  localparam int Q10_SHIFT      = 10;
  localparam int Q15_SHIFT      = 15;
  localparam int RADIUS_Q10     = 461;
  localparam int HOUR_LEN_Q10   = 512;
  localparam int MIN_LEN_Q10    = 768;
  localparam int HOUR_BASE_Q10  = 160;
  localparam int MIN_BASE_Q10   = 120;
  localparam int HOUR_BASE_MIN  = 8;
  localparam int MIN_BASE_MIN   = 6;
  localparam int TICK_LONG      = 16;
  localparam int TICK_SHORT     = 8;
  localparam int TICK_GROUP     = 5;

  localparam int HOURS_FACE     = 12;
  localparam int HOUR_DEG       = 30;
  localparam int MIN_DEG        = 6;
  localparam int DEG_QUARTER    = 90;
  localparam int DEG_HALF       = 180;
  localparam int DEG_3QUARTER   = 270;
  localparam int DEG_FULL       = 360;
  localparam int ANGLE_BIAS     = 270;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DISPLAY_WIDTH   = 2'd0,
    REG_DISPLAY_HEIGHT  = 2'd1,
    REG_CENTER_X_OFFSET = 2'd2,
    REG_CENTER_Y_OFFSET = 2'd3
  } cfg_reg_t;

  localparam logic [14:0] SIN_TAB [0:90] = '{
    15'd0,     15'd572,   15'd1144,  15'd1715,  15'd2286,
    15'd2856,  15'd3425,  15'd3993,  15'd4560,  15'd5126,
    15'd5690,  15'd6252,  15'd6813,  15'd7371,  15'd7927,
    15'd8481,  15'd9032,  15'd9580,  15'd10126, 15'd10668,
    15'd11207, 15'd11743, 15'd12275, 15'd12803, 15'd13328,
    15'd13848, 15'd14364, 15'd14876, 15'd15383, 15'd15886,
    15'd16383, 15'd16876, 15'd17364, 15'd17846, 15'd18323,
    15'd18794, 15'd19260, 15'd19720, 15'd20173, 15'd20621,
    15'd21062, 15'd21497, 15'd21925, 15'd22347, 15'd22762,
    15'd23170, 15'd23571, 15'd23964, 15'd24351, 15'd24730,
    15'd25101, 15'd25465, 15'd25821, 15'd26169, 15'd26509,
    15'd26841, 15'd27165, 15'd27481, 15'd27788, 15'd28087,
    15'd28377, 15'd28659, 15'd28932, 15'd29196, 15'd29451,
    15'd29697, 15'd29934, 15'd30162, 15'd30381, 15'd30591,
    15'd30791, 15'd30982, 15'd31163, 15'd31335, 15'd31498,
    15'd31650, 15'd31794, 15'd31927, 15'd32051, 15'd32165,
    15'd32269, 15'd32364, 15'd32448, 15'd32523, 15'd32587,
    15'd32642, 15'd32687, 15'd32722, 15'd32747, 15'd32762,
    15'd32767
  };

  function automatic logic [8:0] deg_wrap(input logic [9:0] a);
    logic [8:0] r;
    if (a >= 10'(DEG_FULL)) begin
      r = 9'(a - 10'(DEG_FULL));
    end else begin
      r = 9'(a);
    end
    return r;
  endfunction

  function automatic logic signed [15:0] sin_q15(input logic [8:0] a);
    logic [8:0]  idx;
    logic        neg;
    logic [14:0] mag;
    if (a <= 9'(DEG_QUARTER)) begin
      idx = a;
      neg = 1'b0;
    end else if (a <= 9'(DEG_HALF)) begin
      idx = 9'(DEG_HALF) - a;
      neg = 1'b0;
    end else if (a <= 9'(DEG_3QUARTER)) begin
      idx = a - 9'(DEG_HALF);
      neg = 1'b1;
    end else begin
      idx = 9'(DEG_FULL) - a;
      neg = 1'b1;
    end
    mag = SIN_TAB[idx[6:0]];
    return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  function automatic logic signed [15:0] cos_q15(input logic [8:0] a);
    logic [8:0] b;
    b = deg_wrap(10'(a) + 10'(DEG_QUARTER));
    return sin_q15(b);
  endfunction

endpackage

>>> hdl/acfvg_if.sv
// Channel interfaces for the analog clock face vector generator:
// time input, draw command output and configuration write.
// Depends on acfvg_pkg.
interface acfvg_in_if
  import acfvg_pkg::*;
;
  logic       valid;
  logic       ready;
  logic [4:0] hour;
  logic [5:0] minute;

  modport source (output valid, output hour, output minute, input ready);
  modport sink   (input valid, input hour, input minute, output ready);
endinterface

interface acfvg_out_if
  import acfvg_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic                      cmd_kind;
  logic signed [COORD_W-1:0] x0;
  logic signed [COORD_W-1:0] y0;
  logic signed [COORD_W-1:0] x1;
  logic signed [COORD_W-1:0] y1;
  logic signed [COORD_W-1:0] x2;
  logic signed [COORD_W-1:0] y2;
  logic                      first_of_frame;
  logic                      last_of_frame;

  modport source (output valid, output cmd_kind, output x0, output y0, output x1,
                  output y1, output x2, output y2, output first_of_frame,
                  output last_of_frame, input ready);
  modport sink   (input valid, input cmd_kind, input x0, input y0, input x1,
                  input y1, input x2, input y2, input first_of_frame,
                  input last_of_frame, output ready);
endinterface

interface acfvg_cfg_if
  import acfvg_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/analog_clock_face_vector_gen_core.sv
// Top level of the analog clock face vector generator.
// Depends on acfvg_pkg and the channel interfaces in acfvg_if.sv.
//
// Usage: each transfer on in_ch carries a time (hour, minute). The block
// answers with 62 draw commands on out_ch: 60 tick lines, then the hour hand
// and the minute hand as filled triangles. The first command carries
// first_of_frame and the last one last_of_frame.
// cfg_ch writes the display width, height and center offsets; it is always
// ready and should only be used while no frame is in flight.
// Throughput: one command per cycle while out_ch does not stall, set by the
// command sequencer that walks through the command index. The next time is
// taken in the cycle the last command of the current one enters the pipeline.
// After the input transfer, each command passes through a five stage
// pipeline (setup, radius and sine lookup, lengths, multipliers, output
// register).
// Reset restores the default geometry (400 x 300, offsets 0 and 8) and
// empties the pipeline. When out_ch stalls the whole pipeline and the
// sequencer hold; nothing is dropped or repeated.
module analog_clock_face_vector_gen_core
  import acfvg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  acfvg_in_if.sink    in_ch,
  acfvg_out_if.source out_ch,
  acfvg_cfg_if.sink   cfg_ch
);

  typedef struct packed {
    logic              kind;
    logic              first;
    logic              last;
    logic              long_tick;
    logic              min_hand;
    logic signed [10:0] cx;
    logic signed [10:0] cy;
    logic [9:0]        md;
    logic [8:0]        angle;
  } s1_t;

  typedef struct packed {
    logic              kind;
    logic              first;
    logic              last;
    logic              long_tick;
    logic              min_hand;
    logic signed [10:0] cx;
    logic signed [10:0] cy;
    logic [8:0]        radius;
    logic signed [15:0] s;
    logic signed [15:0] c;
  } s2_t;

  typedef struct packed {
    logic              kind;
    logic              first;
    logic              last;
    logic signed [10:0] cx;
    logic signed [10:0] cy;
    logic signed [15:0] s;
    logic signed [15:0] sb;
    logic signed [15:0] c;
    logic signed [10:0] a;
    logic signed [10:0] b;
  } s3_t;

  typedef struct packed {
    logic              kind;
    logic              first;
    logic              last;
    logic signed [10:0] cx;
    logic signed [10:0] cy;
    logic signed [26:0] m1;
    logic signed [26:0] m2;
    logic signed [26:0] m3;
    logic signed [26:0] m4;
  } s4_t;

  typedef struct packed {
    logic                      cmd_kind;
    logic signed [COORD_W-1:0] x0;
    logic signed [COORD_W-1:0] y0;
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic signed [COORD_W-1:0] x2;
    logic signed [COORD_W-1:0] y2;
    logic                      first_of_frame;
    logic                      last_of_frame;
  } out_item_t;

  // Configuration registers.
  logic [9:0]        cfg_w_r, cfg_h_r;
  logic signed [6:0] cfg_cxo_r, cfg_cyo_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r   <= 10'(DEF_WIDTH);
      cfg_h_r   <= 10'(DEF_HEIGHT);
      cfg_cxo_r <= 7'(DEF_CX_OFFSET);
      cfg_cyo_r <= 7'(DEF_CY_OFFSET);
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_DISPLAY_WIDTH:   cfg_w_r   <= cfg_ch.data;
        REG_DISPLAY_HEIGHT:  cfg_h_r   <= cfg_ch.data;
        REG_CENTER_X_OFFSET: cfg_cxo_r <= $signed(cfg_ch.data[6:0]);
        REG_CENTER_Y_OFFSET: cfg_cyo_r <= $signed(cfg_ch.data[6:0]);
        default: begin
        end
      endcase
    end
  end

  // Pipeline advance and command sequencer.
  logic                 out_v_r;
  logic                 adv;
  logic                 busy_r, busy_nxt;
  logic [CMD_IDX_W-1:0] idx_r, idx_nxt;
  logic [2:0]           mod5_r, mod5_nxt;
  logic [4:0]           hour_r, hour_nxt;
  logic [5:0]           minute_r, minute_nxt;
  logic                 issue, last_issue, in_acc;

  assign adv        = !out_v_r || out_ch.ready;
  assign issue      = busy_r && adv;
  assign last_issue = issue && (idx_r == CMD_IDX_W'(NUM_CMDS - 1));
  assign in_ch.ready = !busy_r || last_issue;
  assign in_acc     = in_ch.valid && in_ch.ready;

  always_comb begin
    busy_nxt   = busy_r;
    idx_nxt    = idx_r;
    mod5_nxt   = mod5_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    if (in_acc) begin
      busy_nxt   = 1'b1;
      idx_nxt    = '0;
      mod5_nxt   = '0;
      hour_nxt   = in_ch.hour;
      minute_nxt = in_ch.minute;
    end else if (issue) begin
      if (last_issue) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt  = idx_r + 1'b1;
        mod5_nxt = (mod5_r == 3'(TICK_GROUP - 1)) ? 3'd0 : mod5_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      mod5_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      mod5_r <= mod5_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hour_r   <= hour_nxt;
    minute_r <= minute_nxt;
  end

  // Stage 1: geometry setup and command angle.
  s1_t        s1_nxt, s1_r;
  logic       v1_r;
  logic [9:0] w_eff, h_eff;
  logic [3:0] h12;
  logic [9:0] tick_raw, hour_raw, min_raw, ang_raw;

  always_comb begin
    w_eff = (cfg_w_r == '0) ? 10'(DEF_WIDTH) : cfg_w_r;
    h_eff = (cfg_h_r == '0) ? 10'(DEF_HEIGHT) : cfg_h_r;
    if (hour_r >= 5'(2 * HOURS_FACE)) begin
      h12 = 4'(hour_r - 5'(2 * HOURS_FACE));
    end else if (hour_r >= 5'(HOURS_FACE)) begin
      h12 = 4'(hour_r - 5'(HOURS_FACE));
    end else begin
      h12 = 4'(hour_r);
    end
    tick_raw = 10'(idx_r) * 10'(MIN_DEG) + 10'(ANGLE_BIAS);
    hour_raw = 10'(h12) * 10'(HOUR_DEG) + 10'(minute_r >> 1) + 10'(ANGLE_BIAS);
    min_raw  = 10'(minute_r) * 10'(MIN_DEG) + 10'(ANGLE_BIAS);
    if (idx_r == CMD_IDX_W'(NUM_CMDS - 1)) begin
      ang_raw = min_raw;
    end else if (idx_r == CMD_IDX_W'(NUM_TICKS)) begin
      ang_raw = hour_raw;
    end else begin
      ang_raw = tick_raw;
    end
    s1_nxt.kind      = (idx_r >= CMD_IDX_W'(NUM_TICKS));
    s1_nxt.first     = (idx_r == '0);
    s1_nxt.last      = (idx_r == CMD_IDX_W'(NUM_CMDS - 1));
    s1_nxt.long_tick = (mod5_r == '0);
    s1_nxt.min_hand  = (idx_r == CMD_IDX_W'(NUM_CMDS - 1));
    s1_nxt.cx        = $signed({2'b00, w_eff[9:1]}) + 11'(cfg_cxo_r);
    s1_nxt.cy        = $signed({2'b00, h_eff[9:1]}) + 11'(cfg_cyo_r);
    s1_nxt.md        = (w_eff < h_eff) ? w_eff : h_eff;
    s1_nxt.angle     = deg_wrap(ang_raw);
  end

  // Stage 2: radius and sine/cosine lookup.
  s2_t         s2_nxt, s2_r;
  logic        v2_r;
  logic [18:0] rad_prod;

  always_comb begin
    rad_prod         = 19'(s1_r.md) * 19'(RADIUS_Q10);
    s2_nxt.kind      = s1_r.kind;
    s2_nxt.first     = s1_r.first;
    s2_nxt.last      = s1_r.last;
    s2_nxt.long_tick = s1_r.long_tick;
    s2_nxt.min_hand  = s1_r.min_hand;
    s2_nxt.cx        = s1_r.cx;
    s2_nxt.cy        = s1_r.cy;
    s2_nxt.radius    = rad_prod[18:Q10_SHIFT];
    s2_nxt.s         = sin_q15(s1_r.angle);
    s2_nxt.c         = cos_q15(s1_r.angle);
  end

  // Stage 3: hand lengths, base widths and multiplier operands.
  s3_t         s3_nxt, s3_r;
  logic        v3_r;
  logic [18:0] mlen_prod, hlen_prod, mbase_prod, hbase_prod;
  logic [8:0]  mbase, hbase;
  logic [7:0]  half;
  logic [8:0]  hand_len;

  always_comb begin
    mlen_prod  = 19'(s2_r.radius) * 19'(MIN_LEN_Q10);
    hlen_prod  = 19'(s2_r.radius) * 19'(HOUR_LEN_Q10);
    mbase_prod = 19'(s2_r.radius) * 19'(MIN_BASE_Q10);
    hbase_prod = 19'(s2_r.radius) * 19'(HOUR_BASE_Q10);
    mbase = mbase_prod[18:Q10_SHIFT];
    hbase = hbase_prod[18:Q10_SHIFT];
    if (mbase < 9'(MIN_BASE_MIN)) begin
      mbase = 9'(MIN_BASE_MIN);
    end
    if (hbase < 9'(HOUR_BASE_MIN)) begin
      hbase = 9'(HOUR_BASE_MIN);
    end
    half     = s2_r.min_hand ? mbase[8:1] : hbase[8:1];
    hand_len = s2_r.min_hand ? mlen_prod[18:Q10_SHIFT] : hlen_prod[18:Q10_SHIFT];
    s3_nxt.kind  = s2_r.kind;
    s3_nxt.first = s2_r.first;
    s3_nxt.last  = s2_r.last;
    s3_nxt.cx    = s2_r.cx;
    s3_nxt.cy    = s2_r.cy;
    s3_nxt.s     = s2_r.s;
    s3_nxt.c     = s2_r.c;
    if (s2_r.kind) begin
      s3_nxt.sb = -s2_r.s;
      s3_nxt.a  = $signed({2'b00, hand_len});
      s3_nxt.b  = $signed({3'b000, half});
    end else begin
      s3_nxt.sb = s2_r.s;
      s3_nxt.a  = $signed({2'b00, s2_r.radius});
      s3_nxt.b  = $signed({2'b00, s2_r.radius})
                - (s2_r.long_tick ? 11'(TICK_LONG) : 11'(TICK_SHORT));
    end
  end

  // Stage 4: products.
  s4_t  s4_nxt, s4_r;
  logic v4_r;

  always_comb begin
    s4_nxt.kind  = s3_r.kind;
    s4_nxt.first = s3_r.first;
    s4_nxt.last  = s3_r.last;
    s4_nxt.cx    = s3_r.cx;
    s4_nxt.cy    = s3_r.cy;
    s4_nxt.m1    = 27'(s3_r.c) * 27'(s3_r.a);
    s4_nxt.m2    = 27'(s3_r.s) * 27'(s3_r.a);
    s4_nxt.m3    = 27'(s3_r.c) * 27'(s3_r.b);
    s4_nxt.m4    = 27'(s3_r.sb) * 27'(s3_r.b);
  end

  // Stage 5: scale down, offset by the center and register the command.
  out_item_t                 out_nxt, out_r;
  logic signed [COORD_W-1:0] cx12, cy12, sh1, sh2, sh3, sh4;

  always_comb begin
    cx12 = COORD_W'(s4_r.cx);
    cy12 = COORD_W'(s4_r.cy);
    sh1  = s4_r.m1[26:Q15_SHIFT];
    sh2  = s4_r.m2[26:Q15_SHIFT];
    sh3  = s4_r.m3[26:Q15_SHIFT];
    sh4  = s4_r.m4[26:Q15_SHIFT];
    out_nxt.cmd_kind       = s4_r.kind;
    out_nxt.first_of_frame = s4_r.first;
    out_nxt.last_of_frame  = s4_r.last;
    if (s4_r.kind) begin
      out_nxt.x0 = cx12 + sh4;
      out_nxt.y0 = cy12 + sh3;
      out_nxt.x1 = cx12 - sh4;
      out_nxt.y1 = cy12 - sh3;
      out_nxt.x2 = cx12 + sh1;
      out_nxt.y2 = cy12 + sh2;
    end else begin
      out_nxt.x0 = cx12 + sh3;
      out_nxt.y0 = cy12 + sh4;
      out_nxt.x1 = cx12 + sh1;
      out_nxt.y1 = cy12 + sh2;
      out_nxt.x2 = '0;
      out_nxt.y2 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      v1_r    <= busy_r;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      v4_r    <= v3_r;
      out_v_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r  <= s1_nxt;
      s2_r  <= s2_nxt;
      s3_r  <= s3_nxt;
      s4_r  <= s4_nxt;
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.cmd_kind       = out_r.cmd_kind;
  assign out_ch.x0             = out_r.x0;
  assign out_ch.y0             = out_r.y0;
  assign out_ch.x1             = out_r.x1;
  assign out_ch.y1             = out_r.y1;
  assign out_ch.x2             = out_r.x2;
  assign out_ch.y2             = out_r.y2;
  assign out_ch.first_of_frame = out_r.first_of_frame;
  assign out_ch.last_of_frame  = out_r.last_of_frame;

endmodule

>>> hdl/acfvg_checker.sv
// Port level checker for the analog clock face vector generator, with the
// bind statement that attaches it to the top level.
// Depends on acfvg_pkg.
module acfvg_checker
  import acfvg_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      cmd_kind,
  input logic signed [COORD_W-1:0] x0,
  input logic signed [COORD_W-1:0] x2,
  input logic signed [COORD_W-1:0] y2,
  input logic                      first_of_frame,
  input logic                      last_of_frame
);

  logic                 out_xfer;
  logic [CMD_IDX_W-1:0] cnt_r, cnt_nxt;

  assign out_xfer = out_valid && out_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (out_xfer) begin
      cnt_nxt = (cnt_r == CMD_IDX_W'(NUM_CMDS - 1)) ? '0 : cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(x0) && $stable(cmd_kind)
      && $stable(last_of_frame))
    else $error("stalled command changed");

  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer |-> (first_of_frame == (cnt_r == '0)))
    else $error("first_of_frame out of place");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer |-> (last_of_frame == (cnt_r == CMD_IDX_W'(NUM_CMDS - 1))))
    else $error("last_of_frame out of place");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer |-> (cmd_kind == (cnt_r >= CMD_IDX_W'(NUM_TICKS))))
    else $error("command kind out of order");

  a_tick_tip: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && !cmd_kind |-> (x2 == '0) && (y2 == '0))
    else $error("tick line with nonzero tip");

endmodule

bind analog_clock_face_vector_gen_core acfvg_checker u_acfvg_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .cmd_kind       (out_ch.cmd_kind),
  .x0             (out_ch.x0),
  .x2             (out_ch.x2),
  .y2             (out_ch.y2),
  .first_of_frame (out_ch.first_of_frame),
  .last_of_frame  (out_ch.last_of_frame)
);
